// ----- sv/rcgs_pkg.sv -----
`timescale 1ns / 1ps

package rcgs_pkg;

    // Default sizes of the stores.
    localparam int MAX_RBS_DEF         = 64;
    localparam int MAX_PER_SESSION_DEF = 16;
    localparam int RING_DEPTH_DEF      = 16;
    localparam int RACH_RBS_DEF        = 6;

    // Field widths fixed by the interface.
    localparam int TTI_W  = 16;
    localparam int UE_W   = 10;
    localparam int PRE_W  = 6;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 3;
    localparam int KIND_W = 2;

    // The remainder unit retires one dividend bit per cycle.
    localparam logic [3:0] MOD_LAST = 4'd15;

    localparam logic OP_ARRIVAL = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    localparam logic [KIND_W-1:0] KIND_DONE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_GRANT = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FAIL  = 2'd2;

    localparam logic [CIDX_W-1:0] CFG_REP_INTERVAL  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_PREAMBLE_DUR  = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_RESP_DELAY    = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_RESP_WINDOW   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_NUM_RBS       = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_CCCH_RB_LIMIT = 3'd5;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADV,
        ST_SETUP,
        ST_KSTART,
        ST_KREAD,
        ST_JISSUE,
        ST_JCMP,
        ST_DECIDE,
        ST_SEARCH,
        ST_MOD,
        ST_EMIT,
        ST_FINISH,
        ST_DONE
    } state_t;

endpackage

// ----- sv/rcgs_ram.sv -----
`timescale 1ns / 1ps

module rcgs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- sv/rach_collision_grant_scheduler.sv -----
`timescale 1ns / 1ps

// RACH collision check and message-three grant scheduler.
// The input stream carries one item per transfer: tuser is the operation
// (arrival or tick), tdata the UE id and preamble. An arrival is stored in
// the session of the current TTI, or sets that session's overflow flag once
// it is full, and yields no result. A tick advances the TTI, examines the
// session opened response_delay TTIs earlier, and emits one grant or failure
// per non-collided arrival, followed by a done result with tlast high.
// Collision detection compares every stored pair through the read port of
// the session RAM, and the slot search walks one RB per cycle, pausing at
// each new offset for the RACH test. That test runs a shared restoring
// remainder unit once per examined TTI. Input is not ready until the tick's
// done result has been loaded into the output register. When the receiver
// stalls, the sequencer holds at its next result. Reset (aresetn low,
// synchronous) restores the register defaults, clears TTI counter, session
// counts, overflow flags and CCCH reservations; the session RAM is not
// cleared since only entries below a session's count are ever read.
module rach_collision_grant_scheduler
    import rcgs_pkg::*;
#(
    parameter int MAX_RBS         = rcgs_pkg::MAX_RBS_DEF,
    parameter int MAX_PER_SESSION = rcgs_pkg::MAX_PER_SESSION_DEF,
    parameter int RING_DEPTH      = rcgs_pkg::RING_DEPTH_DEF,
    parameter int RACH_RBS        = rcgs_pkg::RACH_RBS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // ue_id[9:0], preamble[15:10]
    input  logic                          s_tuser,   // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // ue_id_out[9:0], msg3_tti[25:10], msg3_rb[31:26], rach_opportunity[32],
    // overflow[33], zero fill[39:34]
    output logic [39:0]                   m_tdata,
    output logic [rcgs_pkg::KIND_W-1:0]   m_tuser,   // kind
    output logic                          m_tlast,
    input  logic                          cfg_we,
    input  logic [rcgs_pkg::CIDX_W-1:0]   cfg_index,
    input  logic [rcgs_pkg::CFG_W-1:0]    cfg_data
);

    localparam int RW  = $clog2(RING_DEPTH);
    localparam int OW  = $clog2(RING_DEPTH + 1);
    localparam int KW  = $clog2(MAX_PER_SESSION + 1);
    localparam int AW  = $clog2(RING_DEPTH * MAX_PER_SESSION);
    localparam int RBW = $clog2(MAX_RBS);
    localparam int LW  = $clog2(MAX_RBS + 1);
    localparam int SW  = RW + 2;
    localparam int EW  = UE_W + PRE_W;

    // Configuration registers.
    logic [CFG_W-1:0] rep_interval_reg, preamble_dur_reg, num_rbs_reg, ccch_limit_reg;
    logic [3:0]       resp_delay_reg, resp_window_reg;

    state_t state_reg, state_next;

    logic [TTI_W-1:0]  tti_reg, tti_next;
    logic [RW-1:0]     ring_reg, ring_next;
    logic [KW-1:0]     cnt_reg [RING_DEPTH];
    logic [KW-1:0]     cnt_next [RING_DEPTH];
    logic              ovfs_reg [RING_DEPTH];
    logic              ovfs_next [RING_DEPTH];
    logic [MAX_RBS-1:0] ccch_reg [RING_DEPTH];
    logic [MAX_RBS-1:0] ccch_next [RING_DEPTH];
    logic [63:0]       seen_reg, seen_next;

    logic [RW-1:0]     es_reg, es_next;
    logic [KW-1:0]     ecnt_reg, ecnt_next;
    logic              eovf_reg, eovf_next;
    logic [OW-1:0]     win_reg, win_next;
    logic [LW-1:0]     lim_reg, lim_next;
    logic [OW-1:0]     off_reg, off_next;
    logic [LW-1:0]     rb_reg, rb_next;
    logic [KW-1:0]     k_reg, k_next;
    logic [KW-1:0]     j_reg, j_next;
    logic [UE_W-1:0]   kue_reg, kue_next;
    logic [PRE_W-1:0]  kpre_reg, kpre_next;
    logic              coll_reg, coll_next;
    logic              grant_reg, grant_next;
    logic              found_reg, found_next;
    logic [RBW-1:0]    gr_reg, gr_next;
    logic              rach_ok_reg, rach_ok_next;
    logic              rach_reg, rach_next;
    logic              mod_done_reg, mod_done_next;
    logic [3:0]        mod_cnt_reg, mod_cnt_next;
    logic [CFG_W-1:0]  mod_rem_reg, mod_rem_next;
    logic [TTI_W-1:0]  mod_div_reg, mod_div_next;

    logic              m_valid_reg, m_valid_next;
    logic [KIND_W-1:0] m_kind_reg, m_kind_next;
    logic [UE_W-1:0]   m_ue_reg, m_ue_next;
    logic [TTI_W-1:0]  m_tti_reg, m_tti_next;
    logic [5:0]        m_rb_reg, m_rb_next;
    logic              m_opp_reg, m_opp_next;
    logic              m_ovf_reg, m_ovf_next;
    logic              m_last_reg, m_last_next;

    // Session RAM.
    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr, ses_base;
    logic [EW-1:0]     ram_wdata, ram_rdata;

    // Shared conditions.
    logic              out_free, rb_in, rb_blocked, off_over, rd_match, mod_end;
    logic [RW-1:0]     ring_inc, ring_prev, slot, es_calc;
    logic [SW-1:0]     slot_sum, es_sum;
    logic [CFG_W-1:0]  iv;
    logic [CFG_W:0]    mod_t, mod_sub;
    logic [CFG_W-1:0]  mod_rem_new;
    logic [CFG_W-1:0]  lim_min;
    logic              delay_long;

    rcgs_ram #(
        .WIDTH(EW),
        .DEPTH(RING_DEPTH * MAX_PER_SESSION)
    ) u_ses_ram (
        .aclk (aclk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    assign out_free = !m_valid_reg || m_tready;
    assign rb_in    = rb_reg < lim_reg;
    assign off_over = off_reg > win_reg;
    assign mod_end  = mod_cnt_reg == MOD_LAST;
    assign rd_match = (ram_rdata[PRE_W-1:0] == kpre_reg) &&
                      (ram_rdata[EW-1:PRE_W] != kue_reg);

    assign ring_inc  = ({1'b0, ring_reg} + 1'b1 == (RW+1)'(RING_DEPTH)) ? '0 : ring_reg + 1'b1;
    assign ring_prev = (ring_reg == '0) ? RW'(RING_DEPTH - 1) : ring_reg - 1'b1;

    assign slot_sum = SW'(ring_reg) + SW'(off_reg);
    assign slot     = (slot_sum >= SW'(RING_DEPTH)) ? RW'(slot_sum - SW'(RING_DEPTH))
                                                    : RW'(slot_sum);

    assign delay_long = 32'(resp_delay_reg) >= RING_DEPTH;
    assign es_sum     = SW'(ring_reg) + SW'(RING_DEPTH) - SW'(resp_delay_reg);
    assign es_calc    = (es_sum >= SW'(RING_DEPTH)) ? RW'(es_sum - SW'(RING_DEPTH))
                                                    : RW'(es_sum);

    assign rb_blocked = (rach_reg && (32'(rb_reg) < RACH_RBS)) ||
                        ccch_reg[slot][rb_reg[RBW-1:0]];

    // One step of the restoring remainder unit.
    assign iv          = (rep_interval_reg == '0) ? CFG_W'(1) : rep_interval_reg;
    assign mod_t       = {mod_rem_reg, mod_div_reg[TTI_W-1]};
    assign mod_sub     = mod_t - {1'b0, iv};
    assign mod_rem_new = (mod_t >= {1'b0, iv}) ? mod_sub[CFG_W-1:0] : mod_t[CFG_W-1:0];

    assign lim_min = (num_rbs_reg < ccch_limit_reg) ? num_rbs_reg : ccch_limit_reg;

    assign ses_base  = AW'(es_reg) * AW'(MAX_PER_SESSION);
    assign ram_raddr = (state_reg == ST_KSTART) ? ses_base + AW'(k_reg) : ses_base + AW'(j_reg);
    assign ram_waddr = AW'(ring_reg) * AW'(MAX_PER_SESSION) + AW'(cnt_reg[ring_reg]);
    assign ram_wdata = {s_tdata[UE_W-1:0], s_tdata[UE_W+PRE_W-1:UE_W]};

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {6'b0, m_ovf_reg, m_opp_reg, m_rb_reg, m_tti_reg, m_ue_reg};

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == OP_TICK) begin
                    state_next = ST_ADV;
                end
            end
            ST_ADV:    state_next = ST_SETUP;
            ST_SETUP:  state_next = delay_long ? ST_FINISH : ST_KSTART;
            ST_KSTART: state_next = (k_reg < ecnt_reg) ? ST_KREAD : ST_FINISH;
            ST_KREAD:  state_next = ST_JISSUE;
            ST_JISSUE: state_next = (j_reg < ecnt_reg) ? ST_JCMP : ST_DECIDE;
            ST_JCMP:   state_next = ST_JISSUE;
            ST_DECIDE: begin
                state_next = (coll_reg && seen_reg[kpre_reg]) ? ST_KSTART : ST_SEARCH;
            end
            ST_SEARCH: begin
                priority if (off_over) begin
                    state_next = grant_reg ? ST_EMIT : ST_KSTART;
                end else if (!rach_ok_reg) begin
                    state_next = ST_MOD;
                end else if (rb_in && !rb_blocked) begin
                    state_next = grant_reg ? ST_EMIT : ST_KSTART;
                end else begin
                    state_next = ST_SEARCH;
                end
            end
            ST_MOD: begin
                if (mod_end) begin
                    state_next = mod_done_reg ? ST_DONE : ST_SEARCH;
                end
            end
            ST_EMIT:   state_next = out_free ? ST_KSTART : ST_EMIT;
            ST_FINISH: state_next = ST_MOD;
            ST_DONE:   state_next = out_free ? ST_IDLE : ST_DONE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and outputs.
    always_comb begin
        tti_next      = tti_reg;
        ring_next     = ring_reg;
        cnt_next      = cnt_reg;
        ovfs_next     = ovfs_reg;
        ccch_next     = ccch_reg;
        seen_next     = seen_reg;
        es_next       = es_reg;
        ecnt_next     = ecnt_reg;
        eovf_next     = eovf_reg;
        win_next      = win_reg;
        lim_next      = lim_reg;
        off_next      = off_reg;
        rb_next       = rb_reg;
        k_next        = k_reg;
        j_next        = j_reg;
        kue_next      = kue_reg;
        kpre_next     = kpre_reg;
        coll_next     = coll_reg;
        grant_next    = grant_reg;
        found_next    = found_reg;
        gr_next       = gr_reg;
        rach_ok_next  = rach_ok_reg;
        rach_next     = rach_reg;
        mod_done_next = mod_done_reg;
        mod_cnt_next  = mod_cnt_reg;
        mod_rem_next  = mod_rem_reg;
        mod_div_next  = mod_div_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_kind_next   = m_kind_reg;
        m_ue_next     = m_ue_reg;
        m_tti_next    = m_tti_reg;
        m_rb_next     = m_rb_reg;
        m_opp_next    = m_opp_reg;
        m_ovf_next    = m_ovf_reg;
        m_last_next   = m_last_reg;
        ram_we        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == OP_ARRIVAL) begin
                    if (cnt_reg[ring_reg] < KW'(MAX_PER_SESSION)) begin
                        ram_we             = 1'b1;
                        cnt_next[ring_reg] = cnt_reg[ring_reg] + 1'b1;
                    end else begin
                        ovfs_next[ring_reg] = 1'b1;
                    end
                end
            end
            ST_ADV: begin
                tti_next            = tti_reg + 1'b1;
                ring_next           = ring_inc;
                cnt_next[ring_inc]  = '0;
                ovfs_next[ring_inc] = 1'b0;
            end
            ST_SETUP: begin
                if (delay_long) begin
                    eovf_next = 1'b0;
                end else begin
                    es_next      = es_calc;
                    ecnt_next    = cnt_reg[es_calc];
                    eovf_next    = ovfs_reg[es_calc];
                    win_next     = (32'(resp_window_reg) > RING_DEPTH - 1) ?
                                   OW'(RING_DEPTH - 1) : OW'(resp_window_reg);
                    lim_next     = (32'(lim_min) > MAX_RBS) ? LW'(MAX_RBS) : LW'(lim_min);
                    off_next     = OW'(1);
                    rb_next      = '0;
                    rach_ok_next = 1'b0;
                    seen_next    = '0;
                    k_next       = '0;
                end
            end
            ST_KSTART: begin
                if (k_reg >= ecnt_reg) begin
                    cnt_next[es_reg]  = '0;
                    ovfs_next[es_reg] = 1'b0;
                end
            end
            ST_KREAD: begin
                kue_next  = ram_rdata[EW-1:PRE_W];
                kpre_next = ram_rdata[PRE_W-1:0];
                coll_next = 1'b0;
                j_next    = '0;
            end
            ST_JISSUE: begin
            end
            ST_JCMP: begin
                if (rd_match) begin
                    coll_next = 1'b1;
                end
                j_next = j_reg + 1'b1;
            end
            ST_DECIDE: begin
                grant_next = !coll_reg;
                if (coll_reg) begin
                    if (seen_reg[kpre_reg]) begin
                        k_next = k_reg + 1'b1;
                    end else begin
                        seen_next[kpre_reg] = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                priority if (off_over) begin
                    found_next = 1'b0;
                    if (!grant_reg) begin
                        k_next = k_reg + 1'b1;
                    end
                end else if (!rach_ok_reg) begin
                    mod_div_next  = tti_reg + TTI_W'(off_reg);
                    mod_rem_next  = '0;
                    mod_cnt_next  = '0;
                    mod_done_next = 1'b0;
                end else if (rb_in) begin
                    rb_next = rb_reg + 1'b1;
                    if (!rb_blocked) begin
                        found_next = 1'b1;
                        gr_next    = rb_reg[RBW-1:0];
                        if (!grant_reg) begin
                            k_next = k_reg + 1'b1;
                        end
                    end
                end else begin
                    off_next     = off_reg + 1'b1;
                    rb_next      = '0;
                    rach_ok_next = 1'b0;
                end
            end
            ST_MOD: begin
                mod_rem_next = mod_rem_new;
                mod_div_next = {mod_div_reg[TTI_W-2:0], 1'b0};
                mod_cnt_next = mod_cnt_reg + 1'b1;
                if (mod_end) begin
                    rach_next    = mod_rem_new < preamble_dur_reg;
                    rach_ok_next = 1'b1;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_ue_next    = kue_reg;
                    m_opp_next   = 1'b0;
                    m_ovf_next   = eovf_reg;
                    m_last_next  = 1'b0;
                    k_next       = k_reg + 1'b1;
                    if (found_reg) begin
                        m_kind_next = KIND_GRANT;
                        m_tti_next  = tti_reg + TTI_W'(off_reg);
                        m_rb_next   = 6'(gr_reg);
                        ccch_next[slot][gr_reg] = 1'b1;
                    end else begin
                        m_kind_next = KIND_FAIL;
                        m_tti_next  = '0;
                        m_rb_next   = '0;
                    end
                end
            end
            ST_FINISH: begin
                ccch_next[ring_prev] = '0;
                mod_div_next  = tti_reg;
                mod_rem_next  = '0;
                mod_cnt_next  = '0;
                mod_done_next = 1'b1;
            end
            ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = KIND_DONE;
                    m_ue_next    = '0;
                    m_tti_next   = '0;
                    m_rb_next    = '0;
                    m_opp_next   = rach_reg;
                    m_ovf_next   = eovf_reg;
                    m_last_next  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            tti_reg          <= '0;
            ring_reg         <= '0;
            m_valid_reg      <= 1'b0;
            rep_interval_reg <= CFG_W'(5);
            preamble_dur_reg <= CFG_W'(1);
            resp_delay_reg   <= 4'd3;
            resp_window_reg  <= 4'd5;
            num_rbs_reg      <= CFG_W'(25);
            ccch_limit_reg   <= CFG_W'(19);
            for (int i = 0; i < RING_DEPTH; i++) begin
                cnt_reg[i]  <= '0;
                ovfs_reg[i] <= 1'b0;
                ccch_reg[i] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            tti_reg     <= tti_next;
            ring_reg    <= ring_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
            ovfs_reg    <= ovfs_next;
            ccch_reg    <= ccch_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_REP_INTERVAL:  rep_interval_reg <= cfg_data;
                    CFG_PREAMBLE_DUR:  preamble_dur_reg <= cfg_data;
                    CFG_RESP_DELAY:    resp_delay_reg   <= cfg_data[3:0];
                    CFG_RESP_WINDOW:   resp_window_reg  <= cfg_data[3:0];
                    CFG_NUM_RBS:       num_rbs_reg      <= cfg_data;
                    CFG_CCCH_RB_LIMIT: ccch_limit_reg   <= cfg_data;
                    default: begin
                    end
                endcase
            end
        end
    end

    // Working registers of the sequencer carry no reset.
    always_ff @(posedge aclk) begin
        seen_reg     <= seen_next;
        es_reg       <= es_next;
        ecnt_reg     <= ecnt_next;
        eovf_reg     <= eovf_next;
        win_reg      <= win_next;
        lim_reg      <= lim_next;
        off_reg      <= off_next;
        rb_reg       <= rb_next;
        k_reg        <= k_next;
        j_reg        <= j_next;
        kue_reg      <= kue_next;
        kpre_reg     <= kpre_next;
        coll_reg     <= coll_next;
        grant_reg    <= grant_next;
        found_reg    <= found_next;
        gr_reg       <= gr_next;
        rach_ok_reg  <= rach_ok_next;
        rach_reg     <= rach_next;
        mod_done_reg <= mod_done_next;
        mod_cnt_reg  <= mod_cnt_next;
        mod_rem_reg  <= mod_rem_next;
        mod_div_reg  <= mod_div_next;
        m_kind_reg   <= m_kind_next;
        m_ue_reg     <= m_ue_next;
        m_tti_reg    <= m_tti_next;
        m_rb_reg     <= m_rb_next;
        m_opp_reg    <= m_opp_next;
        m_ovf_reg    <= m_ovf_next;
        m_last_reg   <= m_last_next;
    end

`ifndef SYNTHESIS
    // The closing result of a tick is always the done result.
    a_last_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_last_reg |-> m_kind_reg == KIND_DONE)
        else $error("last result of a tick is not a done result");

    // A granted slot must not already be reserved.
    a_grant_free: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_EMIT && out_free && found_reg |-> !ccch_reg[slot][gr_reg])
        else $error("grant issued on a reserved slot");

    // An accepted tick closes the input until its work is done.
    a_tick_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_TICK |=> !s_tready)
        else $error("input accepted during tick processing");

    // Session fill never passes its capacity.
    a_count_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg[ring_reg] <= KW'(MAX_PER_SESSION))
        else $error("session count exceeds capacity");
`endif

endmodule
